[design/lbsh_pkg.sv]
// ============================================================================
// Log-binned size histogram package
// Widths, limits, control types and the result record shared by the design.
// ============================================================================
package lbsh_pkg;

    localparam int SIZE_W       = 31;
    localparam int BASE_W       = 16;
    localparam int CNT_W        = 32;
    localparam int TOTAL_W      = 63;
    localparam int BOUND_W      = 48;
    localparam int BIN_IDX_W    = 5;
    localparam int LOG_W        = 5;
    localparam int NUM_BINS_DEF = 32;

    // Largest exact logarithm of a 31-bit size, reached with base two.
    localparam logic [LOG_W-1:0]     LOG_MAX    = LOG_W'(30);
    // Highest bin index that the readout may report.
    localparam int                   READ_CAP   = 31;
    localparam logic [BASE_W-1:0]    BASE_RESET = BASE_W'(10);
    localparam logic [BASE_W-1:0]    BASE_MIN   = BASE_W'(2);
    localparam logic [CNT_W-1:0]     CNT_MAX    = '1;
    localparam logic [TOTAL_W-1:0]   TOTAL_MAX  = '1;
    localparam logic [BOUND_W-1:0]   BOUND_MAX  = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG,
        ST_BIN_RD,
        ST_BIN_WR,
        ST_RO_LOG,
        ST_RO_RD,
        ST_RO_LOAD
    } lbsh_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;       // capture an item, update statistics, start its log
        logic log_step;     // one multiply-and-compare step of the logarithm
        logic log_init_ro;  // start the logarithm of the largest size
        logic bin_rd;       // read the bin counter selected by the logarithm
        logic bin_wr;       // write back the incremented bin counter
        logic ro_init;      // latch the last bin index, restart at bin zero
        logic ro_rd;        // read the counter of the current readout bin
        logic ro_load;      // load one result into the output register
    } lbsh_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic size_zero;
        logic end_flag;
        logic log_done;
        logic out_free;
        logic ro_last;
    } lbsh_status_t;

    typedef struct packed {
        logic [BIN_IDX_W-1:0] bin_index;
        logic [CNT_W-1:0]     bin_count;
        logic [BOUND_W-1:0]   bin_lower;
        logic [BOUND_W-1:0]   bin_upper;
        logic [CNT_W-1:0]     item_count;
        logic [TOTAL_W-1:0]   size_total;
        logic [SIZE_W-1:0]    max_size;
        logic [CNT_W-1:0]     ones_count;
        logic                 last_bin;
    } lbsh_result_t;

endpackage

[design/lbsh_in_if.sv]
// ============================================================================
// Size input channel
// Valid/ready channel that carries one cluster size and its batch end mark.
// ============================================================================
interface lbsh_in_if import lbsh_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] cluster_size;
    logic              batch_end;

    modport source (output valid, output cluster_size, output batch_end, input ready);
    modport sink   (input valid, input cluster_size, input batch_end, output ready);

endinterface

[design/lbsh_out_if.sv]
// ============================================================================
// Bin result channel
// Valid/ready channel that carries one histogram bin with the batch statistics.
// ============================================================================
interface lbsh_out_if import lbsh_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [BIN_IDX_W-1:0] bin_index;
    logic [CNT_W-1:0]     bin_count;
    logic [BOUND_W-1:0]   bin_lower;
    logic [BOUND_W-1:0]   bin_upper;
    logic [CNT_W-1:0]     item_count;
    logic [TOTAL_W-1:0]   size_total;
    logic [SIZE_W-1:0]    max_size;
    logic [CNT_W-1:0]     ones_count;
    logic                 last_bin;

    modport source (
        output valid, output bin_index, output bin_count, output bin_lower,
        output bin_upper, output item_count, output size_total, output max_size,
        output ones_count, output last_bin, input ready
    );
    modport sink (
        input valid, input bin_index, input bin_count, input bin_lower,
        input bin_upper, input item_count, input size_total, input max_size,
        input ones_count, input last_bin, output ready
    );

endinterface

[design/lbsh_ctrl.sv]
// ============================================================================
// Histogram controller
// Sequences item intake, the iterative logarithm, the bin update and readout.
// ============================================================================
module lbsh_ctrl import lbsh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  lbsh_status_t status,
    output lbsh_cmd_t    cmd
);

    lbsh_state_t state_reg;
    lbsh_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOG;
                end
            end
            ST_LOG:
            begin
                if (status.log_done)
                begin
                    if (!status.size_zero)
                    begin
                        state_next = ST_BIN_RD;
                    end
                    else if (status.end_flag)
                    begin
                        state_next = ST_RO_LOG;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BIN_RD:
            begin
                state_next = ST_BIN_WR;
            end
            ST_BIN_WR:
            begin
                state_next = status.end_flag ? ST_RO_LOG : ST_IDLE;
            end
            ST_RO_LOG:
            begin
                if (status.log_done)
                begin
                    state_next = ST_RO_RD;
                end
            end
            ST_RO_RD:
            begin
                state_next = ST_RO_LOAD;
            end
            ST_RO_LOAD:
            begin
                if (status.out_free)
                begin
                    state_next = status.ro_last ? ST_IDLE : ST_RO_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_LOG:
            begin
                cmd.log_step    = !status.log_done;
                cmd.log_init_ro = status.log_done && status.size_zero && status.end_flag;
            end
            ST_BIN_RD:
            begin
                cmd.bin_rd = 1'b1;
            end
            ST_BIN_WR:
            begin
                cmd.bin_wr      = 1'b1;
                cmd.log_init_ro = status.end_flag;
            end
            ST_RO_LOG:
            begin
                cmd.log_step = !status.log_done;
                cmd.ro_init  = status.log_done;
            end
            ST_RO_RD:
            begin
                cmd.ro_rd = 1'b1;
            end
            ST_RO_LOAD:
            begin
                cmd.ro_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // An accepted item always starts its logarithm in the following cycle.
    a_accept_to_log: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == ST_LOG)
        else $error("accepted item did not enter the logarithm");

    // A counter write-back always follows the read of the same counter.
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bin_wr |-> $past(cmd.bin_rd))
        else $error("bin write-back without a preceding read");

endmodule

[design/lbsh_dp.sv]
// ============================================================================
// Histogram datapath
// Statistics registers, shared base multiplier, bin counter memory and the
// output register.
// ============================================================================
module lbsh_dp import lbsh_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [BASE_W-1:0] cfg_wr_data,
    input  logic [SIZE_W-1:0] in_size,
    input  logic              in_end,
    input  lbsh_cmd_t         cmd,
    output lbsh_status_t      status,
    input  logic              out_ready,
    output logic              out_valid,
    output lbsh_result_t      result
);

    localparam int IDX_W    = $clog2(NUM_BINS);
    localparam int LAST_CAP = (NUM_BINS - 1 < READ_CAP) ? NUM_BINS - 1 : READ_CAP;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        return (x == CNT_MAX) ? x : x + CNT_W'(1);
    endfunction

    logic [BASE_W-1:0]  base_reg;
    logic [BASE_W-1:0]  base_eff;

    logic [CNT_W-1:0]   items_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [SIZE_W-1:0]  largest_reg;
    logic [CNT_W-1:0]   ones_reg;
    logic               end_reg;

    logic [SIZE_W-1:0]  v_reg;
    logic [BOUND_W-1:0] p_reg;
    logic [LOG_W-1:0]   k_reg;
    logic [63:0]        prod;
    logic [BOUND_W-1:0] prod_sat;
    logic [TOTAL_W:0]   sum;

    logic [IDX_W-1:0]   bin_idx;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   i_reg;
    logic [IDX_W-1:0]   last_reg;
    logic [IDX_W-1:0]   last_next;

    logic [CNT_W-1:0]   mem [NUM_BINS];
    logic [CNT_W-1:0]   rdata_reg;
    logic               rd_valid_reg;
    logic [NUM_BINS-1:0] bin_valid_reg;
    logic [CNT_W-1:0]   cur_count;

    logic               out_valid_reg;
    lbsh_result_t       result_reg;
    logic               batch_clear;

    assign base_eff = (base_reg < BASE_MIN) ? BASE_MIN : base_reg;

    // Shared multiplier: next power during the logarithm and the readout.
    assign prod     = p_reg * base_eff;
    assign prod_sat = (prod > 64'(BOUND_MAX)) ? BOUND_MAX : prod[BOUND_W-1:0];

    assign sum = {1'b0, total_reg} + (TOTAL_W+1)'(in_size);

    assign bin_idx   = (int'(k_reg) > NUM_BINS - 1) ? IDX_W'(NUM_BINS - 1) : IDX_W'(k_reg);
    assign last_next = (int'(k_reg) > LAST_CAP) ? IDX_W'(LAST_CAP) : IDX_W'(k_reg);
    assign rd_addr   = cmd.bin_rd ? bin_idx : i_reg;
    assign cur_count = rd_valid_reg ? rdata_reg : '0;

    assign batch_clear = cmd.ro_load && status.ro_last;

    assign status.size_zero = (v_reg == '0);
    assign status.end_flag  = end_reg;
    assign status.log_done  = p_reg > BOUND_W'(v_reg);
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.ro_last   = (i_reg == last_reg);

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
        end
        else if (cfg_wr_en)
        begin
            base_reg <= cfg_wr_data;
        end
    end

    // Batch statistics are updated when the item is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_reg   <= '0;
            total_reg   <= '0;
            largest_reg <= '0;
            ones_reg    <= '0;
            end_reg     <= 1'b0;
        end
        else if (cmd.accept)
        begin
            items_reg <= sat_inc(items_reg);
            total_reg <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
            if (in_size > largest_reg)
            begin
                largest_reg <= in_size;
            end
            if (in_size == SIZE_W'(1))
            begin
                ones_reg <= sat_inc(ones_reg);
            end
            end_reg <= in_end;
        end
        else if (batch_clear)
        begin
            items_reg   <= '0;
            total_reg   <= '0;
            largest_reg <= '0;
            ones_reg    <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            v_reg <= in_size;
        end
        else if (cmd.log_init_ro)
        begin
            v_reg <= largest_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg    <= '0;
            k_reg    <= '0;
            i_reg    <= '0;
            last_reg <= '0;
        end
        else
        begin
            priority if (cmd.accept || cmd.log_init_ro)
            begin
                p_reg <= BOUND_W'(base_eff);
                k_reg <= '0;
            end
            else if (cmd.log_step)
            begin
                p_reg <= prod_sat;
                k_reg <= k_reg + LOG_W'(1);
            end
            else if (cmd.ro_init)
            begin
                p_reg    <= BOUND_W'(1);
                i_reg    <= '0;
                last_reg <= last_next;
            end
            else if (cmd.ro_load)
            begin
                p_reg <= prod_sat;
                i_reg <= i_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bin_wr)
        begin
            mem[bin_idx] <= sat_inc(cur_count);
        end
        if (cmd.bin_rd || cmd.ro_rd)
        begin
            rdata_reg    <= mem[rd_addr];
            rd_valid_reg <= bin_valid_reg[rd_addr];
        end
    end

    // A counter that is not valid reads as zero; the batch end clears all.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= '0;
        end
        else if (batch_clear)
        begin
            bin_valid_reg <= '0;
        end
        else if (cmd.bin_wr)
        begin
            bin_valid_reg[bin_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.ro_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ro_load)
        begin
            result_reg.bin_index  <= BIN_IDX_W'(i_reg);
            result_reg.bin_count  <= cur_count;
            result_reg.bin_lower  <= p_reg;
            result_reg.bin_upper  <= prod_sat;
            result_reg.item_count <= items_reg;
            result_reg.size_total <= total_reg;
            result_reg.max_size   <= largest_reg;
            result_reg.ones_count <= ones_reg;
            result_reg.last_bin   <= status.ro_last;
        end
    end

    // The logarithm of a 31-bit size never runs past its largest value.
    a_log_bound: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= LOG_MAX)
        else $error("logarithm step count out of range");

    // The readout index never passes the latched last bin.
    a_ro_index: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ro_load |-> i_reg <= last_reg)
        else $error("readout past the last bin");

    // Loading the final bin leaves the batch state empty.
    a_batch_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        batch_clear |=> (bin_valid_reg == '0 && items_reg == '0 && largest_reg == '0))
        else $error("batch state not cleared after readout");

endmodule

[design/log_binned_size_histogram_top.sv]
// ============================================================================
// Log-binned size histogram
// Counts a batch of sizes into bins of an integer logarithm and reports them.
// ============================================================================
// Usage:
// Sizes enter one per transfer on in_ch; a transfer with batch_end set closes
// the batch. Each size updates the item count, total, largest size and count
// of ones, and every nonzero size adds one to bin floor(log_base(size)).
// On the closing transfer the block sends bins 0 up to
// floor(log_base(largest)) on out_ch, one transfer per bin, the last one
// marked by last_bin, and then starts a fresh batch.
// One item at a time is handled. Each item gets its exact logarithm, found
// by repeated multiplication by the base in one shared 48 x 16 multiplier,
// then a read and write-back of its bin counter (a zero size skips that
// update). A closing item then adds the logarithm of the largest size and
// the readout of each reported bin in turn, which waits while the output
// register is full and out_ch is not ready.
// The result sits in an output register; when the receiver stalls, the
// readout waits on it, while the input side is free again once the final bin
// has been loaded. log_base must be written through cfg_wr_en/cfg_wr_data only
// while idle; the block does not enforce this. Values below two act as two.
// Reset sets log_base to 10 and empties the histogram.
// ============================================================================
module log_binned_size_histogram_top import lbsh_pkg::*;
#(
    parameter int NUM_BINS = NUM_BINS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [BASE_W-1:0] cfg_wr_data,
    lbsh_in_if.sink           in_ch,
    lbsh_out_if.source        out_ch
);

    lbsh_cmd_t    cmd;
    lbsh_status_t status;
    lbsh_result_t result;
    logic         in_ready;
    logic         out_valid;

    // The controller owns the handshake on the input side.
    lbsh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath owns the statistics, the bin memory and the output register.
    lbsh_dp #(
        .NUM_BINS (NUM_BINS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_size     (in_ch.cluster_size),
        .in_end      (in_ch.batch_end),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (out_ch.ready),
        .out_valid   (out_valid),
        .result      (result)
    );

    assign in_ch.ready       = in_ready;
    assign out_ch.valid      = out_valid;
    assign out_ch.bin_index  = result.bin_index;
    assign out_ch.bin_count  = result.bin_count;
    assign out_ch.bin_lower  = result.bin_lower;
    assign out_ch.bin_upper  = result.bin_upper;
    assign out_ch.item_count = result.item_count;
    assign out_ch.size_total = result.size_total;
    assign out_ch.max_size   = result.max_size;
    assign out_ch.ones_count = result.ones_count;
    assign out_ch.last_bin   = result.last_bin;

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ============================================================================
// Log-binned size histogram testbench
// Sends batches of sizes under a range of log bases through valid/ready
// channels with random gaps and stalls, and checks each reported bin and its
// batch statistics against a behavioral histogram kept in the bench.
// ============================================================================
module testbench;

    import lbsh_pkg::*;

    localparam int      NUM_BINS      = NUM_BINS_DEF;
    localparam int      RAND_ITEMS    = 80;
    // Worst single item: the logarithm and bin update, then the logarithm of
    // the largest size before the readout starts.
    localparam int      SETTLE_CYCLES = 80;
    localparam int      LONG_HOLD     = 400;
    localparam int      PRINT_CAP     = 40;
    localparam longint  TIMEOUT_NS    = 2_000_000;
    localparam longint unsigned SIZE_TOP = 64'h7FFF_FFFF;

    typedef enum bit {ROW_SIZE, ROW_BASE} row_kind_t;

    // One row of the directed table: either a size transfer or a write of the
    // base register. Rows marked typed carry the single bin that they close.
    typedef struct packed {
        row_kind_t          kind;
        logic [BASE_W-1:0]  base;
        logic [SIZE_W-1:0]  size;
        logic               end_mark;
        logic               typed;
        lbsh_result_t       want;
    } stim_row_t;

    localparam lbsh_result_t NO_BIN = '0;

    localparam stim_row_t DIRECTED [0:25] = '{
        // Right after reset the base is ten. An all-zero batch still reports
        // bin zero with bounds one and the base.
        '{ROW_SIZE, 16'd0, 31'd0, 1'b1, 1'b1,
          lbsh_result_t'{5'd0, 32'd0, 48'd1, 48'd10, 32'd1, 63'd0, 31'd0, 32'd0, 1'b1}},
        '{ROW_SIZE, 16'd0, 31'd1, 1'b1, 1'b1,
          lbsh_result_t'{5'd0, 32'd1, 48'd1, 48'd10, 32'd1, 63'd1, 31'd1, 32'd1, 1'b1}},
        // Both sides of the first two powers of ten, a zero, a one and the
        // largest size in one batch.
        '{ROW_SIZE, 16'd0, 31'd9,           1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'd10,          1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'd99,          1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'd100,         1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'd0,           1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'd1,           1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'h7FFF_FFFF,   1'b1, 1'b0, NO_BIN},
        // Smallest base: the readout spans bins 0 to 30.
        '{ROW_BASE, 16'd2,  31'd0,          1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'd1,           1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'd2,           1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'd3,           1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'h4000_0000,   1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'h7FFF_FFFF,   1'b1, 1'b0, NO_BIN},
        // Largest base.
        '{ROW_BASE, 16'hFFFF, 31'd0,        1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'd0,           1'b1, 1'b1,
          lbsh_result_t'{5'd0, 32'd0, 48'd1, 48'd65535, 32'd1, 63'd0, 31'd0, 32'd0, 1'b1}},
        '{ROW_SIZE, 16'd0, 31'd65534,       1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'd65535,       1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'h5555_5555,   1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'h2AAA_AAAA,   1'b1, 1'b0, NO_BIN},
        // Bases below two behave as two.
        '{ROW_BASE, 16'd0,  31'd0,          1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'd0,           1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'd5,           1'b1, 1'b0, NO_BIN},
        '{ROW_BASE, 16'd1,  31'd0,          1'b0, 1'b0, NO_BIN},
        '{ROW_SIZE, 16'd0, 31'd1,           1'b1, 1'b1,
          lbsh_result_t'{5'd0, 32'd1, 48'd1, 48'd2, 32'd1, 63'd1, 31'd1, 32'd1, 1'b1}}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [BASE_W-1:0]  cfg_wr_data;

    lbsh_in_if  in_if ();
    lbsh_out_if out_if ();

    log_binned_size_histogram_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_if),
        .out_ch      (out_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Bench copy of the histogram state and of the base register.
    logic [BASE_W-1:0]  hist_base  = BASE_RESET;
    logic [CNT_W-1:0]   hist_bins [NUM_BINS];
    logic [CNT_W-1:0]   hist_items = '0;
    logic [TOTAL_W-1:0] hist_total = '0;
    logic [SIZE_W-1:0]  hist_max   = '0;
    logic [CNT_W-1:0]   hist_ones  = '0;

    // Bins still owed by the block, oldest first.
    lbsh_result_t       bins_due [$];

    int err_cnt     = 0;
    int bins_seen   = 0;
    int sizes_sent  = 0;
    int batches     = 0;
    int base_writes = 0;
    int long_holds  = 0;
    bit long_hold_req = 1'b0;

    initial
    begin
        foreach (hist_bins[i])
            hist_bins[i] = '0;
    end

    // Adds one bin at the tail of a queue of owed bins.
    function automatic void append_bin(ref lbsh_result_t due[$], input lbsh_result_t r);
        due.insert(due.size(), r);
    endfunction

    // Exact floor of log_b(v) for v of at least one. The product never
    // exceeds v times b, well inside 64 bits.
    function automatic int unsigned exact_log(input longint unsigned v,
                                              input longint unsigned b);
        int unsigned     k;
        longint unsigned p;
        k = 0;
        p = b;
        while (p <= v)
        begin
            k++;
            p = p * b;
        end
        return k;
    endfunction

    // b to the power e, clipped to the bound width.
    function automatic logic [BOUND_W-1:0] bound_pow(input longint unsigned b,
                                                     input int unsigned e);
        longint unsigned r;
        int unsigned     i;
        r = 1;
        for (i = 0; i < e; i++)
        begin
            r = r * b;
            if (r > 64'(BOUND_MAX))
                return BOUND_MAX;
        end
        return r[BOUND_W-1:0];
    endfunction

    // Counts one accepted size into the bench histogram. On a batch end it
    // appends the bins that the block must report and starts a fresh batch.
    function automatic void tally_size(input logic [SIZE_W-1:0] size,
                                       input logic end_mark,
                                       ref lbsh_result_t due[$]);
        longint unsigned b;
        longint unsigned sum;
        int unsigned     k;
        int unsigned     top;
        int unsigned     i;
        lbsh_result_t    r;
        b = (hist_base < BASE_MIN) ? 64'(BASE_MIN) : 64'(hist_base);
        if (hist_items != CNT_MAX)
            hist_items++;
        sum = 64'(hist_total) + 64'(size);
        hist_total = (sum > 64'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        if (size > hist_max)
            hist_max = size;
        if (size == 1 && hist_ones != CNT_MAX)
            hist_ones++;
        if (size != 0)
        begin
            k = exact_log(64'(size), b);
            if (k >= NUM_BINS)
                k = NUM_BINS - 1;
            if (hist_bins[k] != CNT_MAX)
                hist_bins[k]++;
        end
        if (!end_mark)
            return;
        top = (hist_max == 0) ? 0 : exact_log(64'(hist_max), b);
        if (top > NUM_BINS - 1)
            top = NUM_BINS - 1;
        if (top > READ_CAP)
            top = READ_CAP;
        for (i = 0; i <= top; i++)
        begin
            r.bin_index  = i[BIN_IDX_W-1:0];
            r.bin_count  = hist_bins[i];
            r.bin_lower  = bound_pow(b, i);
            r.bin_upper  = bound_pow(b, i + 1);
            r.item_count = hist_items;
            r.size_total = hist_total;
            r.max_size   = hist_max;
            r.ones_count = hist_ones;
            r.last_bin   = (i == top);
            append_bin(due, r);
        end
        foreach (hist_bins[j])
            hist_bins[j] = '0;
        hist_items = '0;
        hist_total = '0;
        hist_max   = '0;
        hist_ones  = '0;
    endfunction

    // Random size biased toward the interesting spots: zero, one, small
    // values and the neighbors of powers of the base. A wide pick spans the
    // whole field so that the readout covers many bins.
    function automatic logic [SIZE_W-1:0] pick_size(input logic [BASE_W-1:0] base_cfg,
                                                     input bit wide);
        longint unsigned b;
        longint unsigned p;
        longint unsigned v;
        int unsigned     steps;
        b = (base_cfg < BASE_MIN) ? 64'(BASE_MIN) : 64'(base_cfg);
        if (wide)
            return SIZE_W'($urandom());
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = 1;
            2: v = $urandom_range(2, 64);
            3:
            begin
                p = 1;
                steps = $urandom_range(1, 30);
                repeat (steps)
                    if (p * b <= SIZE_TOP)
                        p = p * b;
                v = p - 1 + $urandom_range(0, 2);
            end
            4: v = $urandom_range(0, 100000);
            default: v = 64'($urandom()) & SIZE_TOP;
        endcase
        if (v > SIZE_TOP)
            v = SIZE_TOP;
        return v[SIZE_W-1:0];
    endfunction

    // Offers one size from the falling edge and returns at the rising edge
    // where the transfer takes place. Valid stays high until the next call,
    // a pause or a base write reassigns it.
    task automatic offer_size(input logic [SIZE_W-1:0] size, input logic end_mark);
        @(negedge clk);
        in_if.valid        <= 1'b1;
        in_if.cluster_size <= size;
        in_if.batch_end    <= end_mark;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
    endtask

    // Sender gap; the payload wanders while valid is low.
    task automatic pause_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_if.valid        <= 1'b0;
            in_if.cluster_size <= SIZE_W'($urandom());
            in_if.batch_end    <= 1'(($urandom()));
        end
    endtask

    // Writes the base only once every owed bin has come out and the block has
    // had time to finish its last readout.
    task automatic set_base(input logic [BASE_W-1:0] value);
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (bins_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        hist_base = value;
        base_writes++;
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            err_cnt++;
            if (err_cnt <= PRINT_CAP)
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endfunction

    // Bin checker: every transfer on the result channel is matched against the
    // oldest bin still owed.
    lbsh_result_t head_bin;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
        begin
            if (bins_due.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= PRINT_CAP)
                    $display("%0t ns: bin transfer with none owed, expected nothing, actual index %0d",
                             $time, out_if.bin_index);
            end
            else
            begin
                head_bin = bins_due.pop_front();
                check_field("bin_index",  64'(head_bin.bin_index),  64'(out_if.bin_index));
                check_field("bin_count",  64'(head_bin.bin_count),  64'(out_if.bin_count));
                check_field("bin_lower",  64'(head_bin.bin_lower),  64'(out_if.bin_lower));
                check_field("bin_upper",  64'(head_bin.bin_upper),  64'(out_if.bin_upper));
                check_field("item_count", 64'(head_bin.item_count), 64'(out_if.item_count));
                check_field("size_total", 64'(head_bin.size_total), 64'(out_if.size_total));
                check_field("max_size",   64'(head_bin.max_size),   64'(out_if.max_size));
                check_field("ones_count", 64'(head_bin.ones_count), 64'(out_if.ones_count));
                check_field("last_bin",   64'(head_bin.last_bin),   64'(out_if.last_bin));
                bins_seen++;
            end
        end
    end

    // Receiver. It runs stretches of its own: always ready, a coin flip, a
    // mostly stalled spell, or a fixed rotating pattern. When the sender asks
    // for it, it holds off for a long count of cycles so that the output
    // register stays full and the block pushes back on its input.
    initial
    begin : out_side
        int       span;
        int       mode;
        int       held;
        bit [7:0] pattern;
        out_if.ready = 1'b0;
        pattern = 8'b1011_0010;
        forever
        begin
            if (long_hold_req)
            begin
                held = 0;
                while (held < LONG_HOLD)
                begin
                    @(negedge clk);
                    out_if.ready <= 1'b0;
                    held++;
                end
                long_hold_req = 1'b0;
                long_holds++;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 60);
                repeat (span)
                begin
                    @(negedge clk);
                    case (mode)
                        0: out_if.ready <= 1'b1;
                        1: out_if.ready <= 1'(($urandom()));
                        2: out_if.ready <= ($urandom_range(0, 3) == 0);
                        default:
                        begin
                            out_if.ready <= pattern[0];
                            pattern = {pattern[0], pattern[7:1]};
                        end
                    endcase
                end
            end
        end
    end

    // Stimulus: reset, the directed table, then random phases, each under a
    // freshly written base and made of whole batches.
    initial
    begin : stimulus
        lbsh_result_t      scratch [$];
        int unsigned       row;
        int                rand_sizes;
        int                phase;
        int                burst_left;
        int                n_batches;
        int                len;
        int                j;
        bit                pressed;
        logic [BASE_W-1:0] base;
        logic [SIZE_W-1:0] size;

        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        in_if.valid        = 1'b0;
        in_if.cluster_size = '0;
        in_if.batch_end    = 1'b0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < $size(DIRECTED); row++)
        begin
            if (DIRECTED[row].kind == ROW_BASE)
                set_base(DIRECTED[row].base);
            else
            begin
                offer_size(DIRECTED[row].size, DIRECTED[row].end_mark);
                sizes_sent++;
                if (DIRECTED[row].end_mark)
                    batches++;
                // Typed rows still advance the bench state; the bin that the
                // row spells out is what the block must send.
                if (DIRECTED[row].typed)
                begin
                    tally_size(DIRECTED[row].size, DIRECTED[row].end_mark, scratch);
                    scratch.delete();
                    append_bin(bins_due, DIRECTED[row].want);
                end
                else
                    tally_size(DIRECTED[row].size, DIRECTED[row].end_mark, bins_due);
            end
        end

        rand_sizes = 0;
        phase      = 0;
        burst_left = 0;
        while (rand_sizes < RAND_ITEMS)
        begin
            // The second phase is the back-pressure one: base ten, wide
            // sizes, no sender gaps and a long receiver hold-off.
            pressed = (phase == 1);
            if (pressed)
                base = BASE_RESET;
            else
            begin
                case ($urandom_range(0, 5))
                    0: base = BASE_MIN;
                    1: base = '1;
                    2: base = BASE_W'($urandom_range(0, 1));
                    3: base = BASE_W'($urandom_range(3, 16));
                    4: base = BASE_W'($urandom_range(17, 1000));
                    default: base = BASE_W'($urandom_range(1001, 65535));
                endcase
            end
            set_base(base);
            if (pressed)
                long_hold_req = 1'b1;
            n_batches = pressed ? 4 : $urandom_range(2, 4);
            repeat (n_batches)
            begin
                len = $urandom_range(1, 8);
                for (j = 1; j <= len; j++)
                begin
                    if (!pressed && burst_left == 0)
                    begin
                        pause_sender($urandom_range(0, 12));
                        burst_left = $urandom_range(1, 10);
                    end
                    size = pick_size(base, pressed);
                    offer_size(size, j == len);
                    tally_size(size, j == len, bins_due);
                    if (burst_left > 0)
                        burst_left--;
                    rand_sizes++;
                    sizes_sent++;
                end
                batches++;
            end
            phase++;
        end

        @(negedge clk);
        in_if.valid <= 1'b0;
        while (bins_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (bins_due.size() != 0)
        begin
            err_cnt++;
            $display("%0t ns: %0d bins never arrived", $time, bins_due.size());
        end
        $display("Run covered %0d sizes in %0d batches under %0d base writes.",
                 sizes_sent, batches, base_writes);
        $display("Checked %0d bin transfers; the receiver held off %0d time(s).",
                 bins_seen, long_holds);
        if (err_cnt == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Run limit, well above the slowest correct run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Run limit reached with %0d bins still owed.", bins_due.size());
        $display("testbench: errors");
        $finish;
    end

endmodule

[sim.f]
design/lbsh_pkg.sv
design/lbsh_in_if.sv
design/lbsh_out_if.sv
design/lbsh_ctrl.sv
design/lbsh_dp.sv
design/log_binned_size_histogram_top.sv
bench/testbench.sv
